FILE: rtl/sfab_pkg.sv
// Package with shared constants, types and helpers for the shape raster block.
package sfab_pkg;

	localparam int unsigned MAX_WIDTH_DEF  = 64;
	localparam int unsigned MAX_HEIGHT_DEF = 64;
	localparam int unsigned CFG_W          = 7;
	localparam int unsigned COORD_W        = 10;
	localparam int unsigned SIZE_W         = 8;
	localparam int unsigned COLOR_W        = 32;
	localparam int unsigned CMD_W          = 3;
	localparam int unsigned IN_DATA_W      = 72;
	localparam int unsigned OUT_DATA_W     = 40;
	localparam int unsigned CFG_IDX_W      = 1;

	localparam logic [CMD_W-1:0] CMD_FILL = 3'd0;
	localparam logic [CMD_W-1:0] CMD_RECT = 3'd1;
	localparam logic [CMD_W-1:0] CMD_DISC = 3'd2;
	localparam logic [CMD_W-1:0] CMD_RING = 3'd3;
	localparam logic [CMD_W-1:0] CMD_OCT  = 3'd4;
	localparam logic [CMD_W-1:0] CMD_READ = 3'd5;

	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;

	localparam logic [COLOR_W-1:0] RESET_PIXEL = 32'h0000_00FF;
	localparam logic [7:0]         ALPHA_FULL  = 8'hFF;

	// Octagon cut scale factors: (dx+dy)*OCT_NUM_L <= h*OCT_NUM_R.
	localparam logic [26:0] OCT_NUM_L = 27'd100000000;
	localparam logic [27:0] OCT_NUM_R = 28'd141421356;

	// Quotient by 255 of a value below 65280: floor(v/255) via reciprocal.
	function automatic logic [7:0] div255(input logic [15:0] v);
		logic [16:0] t;
		begin
			t = {1'b0, v} + 17'd1 + {9'd0, v[15:8]};
			div255 = t[15:8];
		end
	endfunction

	typedef struct packed {
		logic [CMD_W-1:0]   kind;
		logic [COLOR_W-1:0] color;
	} draw_ctl_t;

endpackage

FILE: rtl/sfab_blend.sv
// Per-pixel shared compute unit: shape membership test and alpha blend.
module sfab_blend (
	input  logic                           clk,
	input  logic                           load,
	input  sfab_pkg::draw_ctl_t            ctl,
	input  logic [10:0]                    dx,
	input  logic [10:0]                    dy,
	input  logic [sfab_pkg::SIZE_W-1:0]    a,
	input  logic [sfab_pkg::SIZE_W-1:0]    b,
	input  logic [sfab_pkg::COLOR_W-1:0]   base,
	output logic                           write_s1,
	output logic [sfab_pkg::COLOR_W-1:0]   pixel_s1
);
	logic [21:0] d2;
	logic [15:0] a2, in2;
	logic [7:0]  inner;
	logic [11:0] dsum;
	logic        hit;
	logic [7:0]  ab, at, inv;
	logic [15:0] prod [0:3];
	logic [31:0] mix;

	always_comb begin
		d2 = 22'(dx * dx) + 22'(dy * dy);
		a2 = a * a;
		inner = a - b;
		in2 = inner * inner;
		dsum = {1'b0, dx} + {1'b0, dy};
		case (ctl.kind)
			sfab_pkg::CMD_RECT: hit = 1'b1;
			sfab_pkg::CMD_DISC: hit = (d2 <= {6'd0, a2}) && (base != ctl.color);
			sfab_pkg::CMD_RING: hit = (d2 <= {6'd0, a2}) && (base != ctl.color) &&
				((b >= a) || (d2 > {6'd0, in2}));
			sfab_pkg::CMD_OCT: hit = (39'(dsum) * 39'(sfab_pkg::OCT_NUM_L)) <=
				(39'(a) * 39'(sfab_pkg::OCT_NUM_R));
			default: hit = 1'b0;
		endcase
		ab = base[7:0];
		at = ctl.color[7:0];
		inv = sfab_pkg::ALPHA_FULL - at;
		for (int c = 1; c < 4; c++) begin
			prod[c] = 16'(base[c*8 +: 8] * inv) + 16'(ctl.color[c*8 +: 8] * at);
		end
		prod[0] = 16'(ab * inv) + 16'd127;
		if (ab == 8'd0 || at == sfab_pkg::ALPHA_FULL) begin
			mix = ctl.color;
		end else if (at == 8'd0) begin
			mix = base;
		end else begin
			mix = {sfab_pkg::div255(prod[3]), sfab_pkg::div255(prod[2]),
				sfab_pkg::div255(prod[1]), 8'(at + sfab_pkg::div255(prod[0]))};
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			write_s1 <= hit;
			pixel_s1 <= mix;
		end
	end
endmodule

FILE: rtl/shape_fill_alpha_blend_raster.sv
// Top level of the shape raster: command sequencer, frame store and stream ports.
//
//  Channel  | Direction | Contents
//  s_axis   | in        | tdata: command, center_x, center_y, size_a, size_b, color
//  m_axis   | out       | tdata: read_color, read_in_bounds
//  cfg      | in        | register 0 canvas_width, register 1 canvas_height
//
// A shape command walks its clipped bounding box one pixel at a time, each
// through memory read, blend unit and write back before the next pixel starts.
// A fill or the clearing pass after reset writes one store entry per cycle,
// covering all MAX_WIDTH*MAX_HEIGHT entries. A read inside the canvas passes
// through a memory read state and a data capture state before its result is
// valid. After reset the store is swept to opaque black before the first
// transaction is taken.
// The result waits in an output register; a stalled output only holds it.
module shape_fill_alpha_blend_raster #(
	parameter int unsigned MAX_WIDTH  = sfab_pkg::MAX_WIDTH_DEF,
	parameter int unsigned MAX_HEIGHT = sfab_pkg::MAX_HEIGHT_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// command[2:0], center_x[12:3], center_y[22:13], size_a[30:23],
	// size_b[38:31], color[70:39], zero pad[71]
	input  logic [sfab_pkg::IN_DATA_W-1:0]     s_axis_tdata,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// read_color[31:0], read_in_bounds[32], zero pad[39:33]
	output logic [sfab_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
	input  logic                               cfg_we,
	input  logic [sfab_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [sfab_pkg::CFG_W-1:0]         cfg_data
);
	localparam int unsigned XW    = $clog2(MAX_WIDTH) > 0 ? $clog2(MAX_WIDTH) : 1;
	localparam int unsigned YW    = $clog2(MAX_HEIGHT) > 0 ? $clog2(MAX_HEIGHT) : 1;
	localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int unsigned AW    = $clog2(DEPTH) > 0 ? $clog2(DEPTH) : 1;
	localparam int unsigned CW    = 12;

	typedef enum logic [6:0] {
		ST_CLEAR = 7'b0000001,
		ST_IDLE  = 7'b0000010,
		ST_FILL  = 7'b0000100,
		ST_RD    = 7'b0001000,
		ST_CALC  = 7'b0010000,
		ST_WR    = 7'b0100000,
		ST_OUT   = 7'b1000000
	} state_t;

	state_t                         state_q;
	logic [sfab_pkg::CFG_W-1:0]     width_q, height_q;
	logic [sfab_pkg::COLOR_W-1:0]   mem [0:DEPTH-1];
	logic [sfab_pkg::COLOR_W-1:0]   rdata_q;
	logic [AW:0]                    sweep_q;
	sfab_pkg::draw_ctl_t            ctl_q;
	logic signed [CW-1:0]           cx_q, cy_q, x_q, y_q, x0_q, x1_q, y1_q;
	logic [sfab_pkg::SIZE_W-1:0]    a_q, b_q;
	logic                           is_read_q;
	logic [sfab_pkg::COLOR_W-1:0]   out_color_q;
	logic                           out_inb_q;
	logic                           blend_wr_s1;
	logic [sfab_pkg::COLOR_W-1:0]   blend_px_s1;

	// Unpacked input fields.
	logic [sfab_pkg::CMD_W-1:0]     in_cmd;
	logic signed [CW-1:0]           in_cx, in_cy, rx, ry, aw, ah;
	logic [sfab_pkg::SIZE_W-1:0]    in_a, in_b, eff_a;
	logic signed [CW-1:0]           bx0, bx1, by0, by1;
	logic [10:0]                    dx, dy;
	logic [AW-1:0]                  addr;
	logic                           accept;

	assign in_cmd = s_axis_tdata[2:0];
	assign in_cx  = CW'(signed'(s_axis_tdata[12:3]));
	assign in_cy  = CW'(signed'(s_axis_tdata[22:13]));
	assign in_a   = s_axis_tdata[30:23];
	assign in_b   = s_axis_tdata[38:31];
	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = (state_q == ST_OUT);
	assign m_axis_tdata = {7'd0, out_inb_q, out_color_q};

	// Active canvas clipped to the store size.
	always_comb begin
		aw = (32'(width_q) > MAX_WIDTH) ? CW'(MAX_WIDTH) : CW'(width_q);
		ah = (32'(height_q) > MAX_HEIGHT) ? CW'(MAX_HEIGHT) : CW'(height_q);
		eff_a = (in_cmd == sfab_pkg::CMD_OCT) ? (in_a >> 1) : in_a;
		rx = CW'(eff_a);
		ry = (in_cmd == sfab_pkg::CMD_RECT) ? CW'(in_b) : CW'(eff_a);
		bx0 = (in_cx - rx < 0) ? CW'(0) : in_cx - rx;
		by0 = (in_cy - ry < 0) ? CW'(0) : in_cy - ry;
		bx1 = (in_cx + rx > aw - 1) ? aw - 1 : in_cx + rx;
		by1 = (in_cy + ry > ah - 1) ? ah - 1 : in_cy + ry;
		dx = (x_q > cx_q) ? 11'(x_q - cx_q) : 11'(cx_q - x_q);
		dy = (y_q > cy_q) ? 11'(y_q - cy_q) : 11'(cy_q - y_q);
		addr = AW'(y_q[YW-1:0] * MAX_WIDTH) + AW'(x_q[XW-1:0]);
	end

	sfab_blend u_blend (
		.clk      (clk),
		.load     (state_q == ST_CALC),
		.ctl      (ctl_q),
		.dx       (dx),
		.dy       (dy),
		.a        (a_q),
		.b        (b_q),
		.base     (rdata_q),
		.write_s1 (blend_wr_s1),
		.pixel_s1 (blend_px_s1)
	);

	// Frame store: one write port and one read port, read data registered.
	always_ff @(posedge clk) begin
		if (state_q == ST_CLEAR) begin
			mem[sweep_q[AW-1:0]] <= sfab_pkg::RESET_PIXEL;
		end else if (state_q == ST_FILL) begin
			mem[sweep_q[AW-1:0]] <= ctl_q.color;
		end else if (state_q == ST_WR && blend_wr_s1) begin
			mem[addr] <= blend_px_s1;
		end
		rdata_q <= mem[addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			width_q  <= sfab_pkg::CFG_W'(64);
			height_q <= sfab_pkg::CFG_W'(64);
			sweep_q  <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == sfab_pkg::REG_WIDTH) width_q <= cfg_data;
				else height_q <= cfg_data;
			end
			case (state_q)
				ST_CLEAR, ST_FILL: begin
					sweep_q <= sweep_q + 1'b1;
					if (32'(sweep_q) == DEPTH - 1) begin
						sweep_q <= '0;
						state_q <= (state_q == ST_CLEAR) ? ST_IDLE : ST_OUT;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_OUT;
						if (in_cmd == sfab_pkg::CMD_FILL) begin
							state_q <= ST_FILL;
						end else if (in_cmd == sfab_pkg::CMD_READ) begin
							if (in_cx >= 0 && in_cy >= 0 && in_cx < aw && in_cy < ah) begin
								state_q <= ST_RD;
							end
						end else if (in_cmd >= sfab_pkg::CMD_RECT &&
							in_cmd <= sfab_pkg::CMD_OCT) begin
							if (bx0 <= bx1 && by0 <= by1) state_q <= ST_RD;
						end
					end
				end
				ST_RD: state_q <= ST_CALC;
				// A read has its store data in rdata_q here and finishes.
				ST_CALC: state_q <= is_read_q ? ST_OUT : ST_WR;
				ST_WR: begin
					state_q <= ST_RD;
					if (x_q == x1_q) begin
						if (y_q == y1_q) state_q <= ST_OUT;
					end
				end
				ST_OUT: if (m_axis_tready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Command capture and pixel walk; payload registers need no reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			ctl_q.kind  <= in_cmd;
			ctl_q.color <= s_axis_tdata[70:39];
			cx_q <= in_cx;
			cy_q <= in_cy;
			a_q  <= eff_a;
			b_q  <= in_b;
			is_read_q   <= (in_cmd == sfab_pkg::CMD_READ);
			out_color_q <= '0;
			out_inb_q   <= 1'b0;
			if (in_cmd == sfab_pkg::CMD_READ) begin
				x_q <= in_cx;
				y_q <= in_cy;
			end else begin
				x_q <= bx0;
				y_q <= by0;
			end
			x0_q <= bx0;
			x1_q <= bx1;
			y1_q <= by1;
		end
		if (state_q == ST_CALC && is_read_q) begin
			out_color_q <= rdata_q;
			out_inb_q   <= 1'b1;
		end
		if (state_q == ST_WR) begin
			if (x_q == x1_q) begin
				x_q <= x0_q;
				y_q <= y_q + 1'b1;
			end else begin
				x_q <= x_q + 1'b1;
			end
		end
	end
endmodule

FILE: test/tb_shape_fill_alpha_blend_raster.sv
// Self-checking testbench for the shape raster block with an in-bench frame store predictor.
module tb_shape_fill_alpha_blend_raster;
	timeunit 1ns;
	timeprecision 1ps;

	// The two command codes the block treats as no-ops.
	localparam logic [sfab_pkg::CMD_W-1:0] CMD_SPARE_A = 3'd6;
	localparam logic [sfab_pkg::CMD_W-1:0] CMD_SPARE_B = 3'd7;
	localparam int STORE_W     = 64;
	localparam int STORE_H     = 64;
	localparam int CYCLE_LIMIT = 12_000_000;
	localparam int IDLE_PCT    = 27;

	typedef struct {
		logic [sfab_pkg::COLOR_W-1:0] pixel;
		logic                         in_bounds;
	} read_result_t;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            s_axis_tvalid = 1'b0;
	logic                            s_axis_tready;
	// command, center_x, center_y, size_a, size_b, color, zero pad (lowest bit up)
	logic [sfab_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic                            m_axis_tvalid;
	logic                            m_axis_tready = 1'b0;
	// read_color, read_in_bounds, zero pad (lowest bit up)
	logic [sfab_pkg::OUT_DATA_W-1:0] m_axis_tdata;
	logic                            cfg_we = 1'b0;
	logic [sfab_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [sfab_pkg::CFG_W-1:0]      cfg_data = '0;

	// Predictor state: a private copy of the frame store and the canvas size.
	logic [sfab_pkg::COLOR_W-1:0] pixels [0:STORE_W*STORE_H-1];
	int                 canvas_w;
	int                 canvas_h;
	read_result_t       pending_reads [$];
	bit                 steady_flow;
	int                 mismatches;
	int                 cycles;

	always #6 clk = ~clk;

	shape_fill_alpha_blend_raster DUT (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Blend of a top color over a base pixel, channel by channel.
	function automatic logic [31:0] blend_over(logic [31:0] base, logic [31:0] top);
		int unsigned ab, at, inv, c;
		logic [31:0] res;
		ab = base[7:0];
		at = top[7:0];
		if (ab == 0 || at == 255) return top;
		if (at == 0) return base;
		inv = 255 - at;
		res = '0;
		for (int sh = 8; sh <= 24; sh += 8) begin
			c = ((base >> sh) & 8'hFF) * inv + ((top >> sh) & 8'hFF) * at;
			res |= ((c / 255) & 8'hFF) << sh;
		end
		res[7:0] = 8'(at + (ab * inv + 127) / 255);
		return res;
	endfunction

	function automatic bit covers(logic [2:0] kind, int dx, int dy, int a, int b);
		int d2;
		d2 = dx * dx + dy * dy;
		case (kind)
			sfab_pkg::CMD_RECT: return 1'b1;
			sfab_pkg::CMD_DISC: return d2 <= a * a;
			sfab_pkg::CMD_RING: begin
				if (d2 > a * a) return 1'b0;
				if (b >= a) return 1'b1;
				return d2 > (a - b) * (a - b);
			end
			default: return longint'(dx + dy) * 64'd100000000 <= longint'(a) * 64'd141421356;
		endcase
	endfunction

	task automatic rasterize(logic [2:0] kind, int cx, int cy, int a, int b, logic [31:0] col);
		int rx, ry, x0, x1, y0, y1, w, h, dx, dy, idx;
		w = canvas_w > STORE_W ? STORE_W : canvas_w;
		h = canvas_h > STORE_H ? STORE_H : canvas_h;
		if (kind == sfab_pkg::CMD_OCT) a = a >> 1;
		rx = a;
		ry = (kind == sfab_pkg::CMD_RECT) ? b : a;
		x0 = cx - rx < 0 ? 0 : cx - rx;
		y0 = cy - ry < 0 ? 0 : cy - ry;
		x1 = cx + rx > w - 1 ? w - 1 : cx + rx;
		y1 = cy + ry > h - 1 ? h - 1 : cy + ry;
		for (int y = y0; y <= y1; y++) begin
			for (int x = x0; x <= x1; x++) begin
				idx = y * STORE_W + x;
				dx = x > cx ? x - cx : cx - x;
				dy = y > cy ? y - cy : cy - y;
				// Discs and rings leave pixels that already hold the color.
				if ((kind == sfab_pkg::CMD_DISC || kind == sfab_pkg::CMD_RING) &&
						pixels[idx] == col) continue;
				if (covers(kind, dx, dy, a, b)) pixels[idx] = blend_over(pixels[idx], col);
			end
		end
	endtask

	// Applies one command to the predicted store and queues its result.
	task automatic apply_command(logic [2:0] kind, int cx, int cy, int a, int b,
			logic [31:0] col);
		read_result_t r;
		r.pixel = '0;
		r.in_bounds = 1'b0;
		if (kind == sfab_pkg::CMD_FILL) begin
			for (int i = 0; i < STORE_W * STORE_H; i++) pixels[i] = col;
		end else if (kind >= sfab_pkg::CMD_RECT && kind <= sfab_pkg::CMD_OCT) begin
			rasterize(kind, cx, cy, a, b, col);
		end else if (kind == sfab_pkg::CMD_READ) begin
			if (cx >= 0 && cy >= 0 && cx < canvas_w && cx < STORE_W
					&& cy < canvas_h && cy < STORE_H) begin
				r.pixel = pixels[cy * STORE_W + cx];
				r.in_bounds = 1'b1;
			end
		end
		pending_reads = {pending_reads, r};
	endtask

	// Sends one command transaction, sometimes after a random gap, and predicts it.
	task automatic send_command(logic [2:0] kind, int cx, int cy, int a, int b,
			logic [31:0] col);
		logic signed [9:0] x10, y10;
		x10 = cx;
		y10 = cy;
		if (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {1'b0, col, b[7:0], a[7:0], y10, x10, kind};
		do @(posedge clk); while (!s_axis_tready);
		apply_command(kind, x10, y10, a[7:0], b[7:0], col);
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (pending_reads.size() != 0) @(posedge clk);
	endtask

	// Register writes happen only with the block idle.
	task automatic write_canvas(logic [sfab_pkg::CFG_IDX_W-1:0] idx, int val);
		wait_drained();
		repeat (8) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[sfab_pkg::CFG_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == sfab_pkg::REG_WIDTH) canvas_w = val[sfab_pkg::CFG_W-1:0];
		else canvas_h = val[sfab_pkg::CFG_W-1:0];
	endtask

	function automatic logic [31:0] pick_color();
		logic [31:0] c;
		c = $urandom;
		case ($urandom_range(3))
			0: c[7:0] = 8'h00;
			1: c[7:0] = sfab_pkg::ALPHA_FULL;
			default: ;
		endcase
		return c;
	endfunction

	// Reset contents, corners, out-of-range reads and the spare commands.
	task automatic test_reset_contents();
		send_command(sfab_pkg::CMD_READ, 0, 0, 0, 0, 0);
		send_command(sfab_pkg::CMD_READ, 63, 63, 0, 0, 0);
		send_command(sfab_pkg::CMD_READ, -1, 5, 0, 0, 0);
		send_command(sfab_pkg::CMD_READ, 64, 0, 0, 0, 0);
		send_command(sfab_pkg::CMD_READ, -512, 511, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
		send_command(CMD_SPARE_A, 3, 3, 4, 4, 32'hDEAD_BEEF);
		send_command(CMD_SPARE_B, 3, 3, 4, 4, 32'h1234_5678);
		send_command(sfab_pkg::CMD_READ, 3, 3, 0, 0, 0);
		wait_drained();
	endtask

	// Every shape, each blend branch, thick rings and clipping at the extremes.
	task automatic test_shapes_and_blend();
		send_command(sfab_pkg::CMD_RECT, 10, 10, 3, 1, 32'h80C0_4080);
		send_command(sfab_pkg::CMD_READ, 10, 10, 0, 0, 0);
		send_command(sfab_pkg::CMD_DISC, 20, 20, 5, 0, 32'h1020_30FF);
		send_command(sfab_pkg::CMD_DISC, 20, 20, 6, 0, 32'h1020_30FF);
		send_command(sfab_pkg::CMD_RING, 40, 20, 9, 3, 32'hFF00_0040);
		send_command(sfab_pkg::CMD_RING, 40, 40, 4, 9, 32'h00FF_00C0);
		send_command(sfab_pkg::CMD_OCT, 12, 45, 13, 0, 32'h0000_FF7F);
		send_command(sfab_pkg::CMD_RECT, 30, 30, 5, 5, 32'hABCD_EF00);
		send_command(sfab_pkg::CMD_READ, 20, 20, 0, 0, 0);
		send_command(sfab_pkg::CMD_READ, 44, 20, 0, 0, 0);
		// Base alpha zero: the next draw replaces outright.
		send_command(sfab_pkg::CMD_FILL, 0, 0, 0, 0, 32'h4488_CC00);
		send_command(sfab_pkg::CMD_DISC, 0, 0, 255, 0, 32'h2244_6601);
		send_command(sfab_pkg::CMD_READ, 63, 0, 0, 0, 0);
		send_command(sfab_pkg::CMD_RECT, -512, -512, 255, 255, 32'h0102_0380);
		send_command(sfab_pkg::CMD_OCT, 511, 511, 255, 255, 32'hFEDC_BA11);
		send_command(sfab_pkg::CMD_READ, 63, 63, 0, 0, 0);
		send_command(sfab_pkg::CMD_READ, 0, 0, 0, 0, 0);
		wait_drained();
	endtask

	// Small, zero, oversized and odd canvas settings with clipping checks.
	task automatic test_canvas_sizes();
		int sizes_w [5] = '{1, 0, 127, 17, 64};
		int sizes_h [5] = '{1, 64, 0, 33, 64};
		for (int i = 0; i < 5; i++) begin
			write_canvas(sfab_pkg::REG_WIDTH, sizes_w[i]);
			write_canvas(sfab_pkg::REG_HEIGHT, sizes_h[i]);
			send_command(sfab_pkg::CMD_RECT, 0, 0, 40, 40, 32'h7711_33A0);
			send_command(sfab_pkg::CMD_RING, 16, 16, 20, 4, pick_color());
			for (int k = 0; k < 3; k++)
				send_command(sfab_pkg::CMD_READ, $urandom_range(70), $urandom_range(70),
					0, 0, 0);
			send_command(sfab_pkg::CMD_READ, sizes_w[i] - 1, sizes_h[i] - 1, 0, 0, 0);
			send_command(sfab_pkg::CMD_READ, sizes_w[i], 0, 0, 0, 0);
		end
		wait_drained();
	endtask

	// Random commands: mostly small shapes near the canvas, plenty of reads.
	task automatic test_random_commands(int count);
		logic [2:0] kind;
		int cx, cy, a, b, pick;
		logic [31:0] col;
		for (int n = 0; n < count; n++) begin
			if (n == count / 3) write_canvas(sfab_pkg::REG_WIDTH, $urandom_range(64, 1));
			if (n == count / 3) write_canvas(sfab_pkg::REG_HEIGHT, $urandom_range(64, 1));
			if (n == count / 2) wait_drained();
			steady_flow = (n >= 2 * count / 3) && (n < 2 * count / 3 + 25);
			pick = $urandom_range(99);
			if (pick < 2) kind = sfab_pkg::CMD_FILL;
			else if (pick < 4) kind = $urandom_range(1) ? CMD_SPARE_A : CMD_SPARE_B;
			else if (pick < 40) kind = sfab_pkg::CMD_READ;
			else kind = $urandom_range(sfab_pkg::CMD_OCT, sfab_pkg::CMD_RECT);
			if ($urandom_range(9) == 0) begin
				cx = $urandom_range(1023) - 512;
				cy = $urandom_range(1023) - 512;
			end else begin
				cx = $urandom_range(72) - 6;
				cy = $urandom_range(72) - 6;
			end
			a = ($urandom_range(24) == 0) ? $urandom_range(255) : $urandom_range(12);
			b = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(12);
			col = pick_color();
			// Reuse a stored pixel so the skip-equal rule for discs and rings is hit.
			if ($urandom_range(5) == 0 && cx >= 0 && cx < 64 && cy >= 0 && cy < 64)
				col = pixels[cy * STORE_W + cx];
			send_command(kind, cx, cy, a, b, col);
		end
		steady_flow = 1'b0;
		wait_drained();
	endtask

	// Result checker; the receiver also stalls at random here.
	always @(posedge clk) begin
		read_result_t want;
		m_axis_tready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_reads.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h", m_axis_tdata);
			end else begin
				want = pending_reads.pop_front();
				if (m_axis_tdata[31:0] !== want.pixel) begin
					mismatches++;
					if (mismatches <= 10)
						$display("read_color: expected %h, got %h", want.pixel,
							m_axis_tdata[31:0]);
				end
				if (m_axis_tdata[32] !== want.in_bounds) begin
					mismatches++;
					if (mismatches <= 10)
						$display("read_in_bounds: expected %b, got %b", want.in_bounds,
							m_axis_tdata[32]);
				end
			end
		end
	end

	// Watchdog against a hung handshake.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("[shape_fill_alpha_blend_raster] ERROR");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < STORE_W * STORE_H; i++) pixels[i] = sfab_pkg::RESET_PIXEL;
		canvas_w = 64;
		canvas_h = 64;
		mismatches = 0;
		cycles = 0;
		steady_flow = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_contents();
		test_shapes_and_blend();
		test_canvas_sizes();
		test_random_commands(80);
		repeat (20) @(posedge clk);
		if (mismatches == 0 && pending_reads.size() == 0)
			$display("[shape_fill_alpha_blend_raster] OK");
		else
			$display("[shape_fill_alpha_blend_raster] ERROR");
		$finish;
	end
endmodule
